@@ sv/hbd_pkg.sv @@
// Shared types and constants for the Huffman tree bit decoder.
// No dependencies; used by every module of the block.
`default_nettype none
package hbd_pkg;

    localparam int SYM_W            = 8;
    localparam int POS_W            = 3;
    localparam int NODE_COUNT_DEF   = 512;
    localparam int MAX_CODE_LEN_DEF = 32;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_DECODE = 1'b1;

    typedef enum logic [1:0] {
        ST_SYMBOL  = 2'd0,
        ST_INVALID = 2'd1,
        ST_LOADED  = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    // result event from the tree walker to the result stage
    typedef struct packed {
        logic             push;
        logic             flush;
        logic [SYM_W-1:0] symbol;
        logic [POS_W-1:0] bit_pos;
        t_status          status;
    } t_res_ev;

endpackage
`default_nettype wire

@@ sv/hbd_node_mem.sv @@
// Node store: root entry in flops cleared by reset, other nodes in a RAM.
// Word layout {left, right, symbol}. Depends on hbd_pkg.
`default_nettype none
module hbd_node_mem #(
    parameter int NODE_COUNT = hbd_pkg::NODE_COUNT_DEF
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_rd_en,
    input  wire logic [$clog2(NODE_COUNT)-1:0]           i_rd_addr,
    output logic [2*$clog2(NODE_COUNT)+hbd_pkg::SYM_W-1:0] o_rd_data,
    output logic [2*$clog2(NODE_COUNT)+hbd_pkg::SYM_W-1:0] o_root_word,
    input  wire logic                                    i_wr_en,
    input  wire logic [$clog2(NODE_COUNT)-1:0]           i_wr_addr,
    input  wire logic [2*$clog2(NODE_COUNT)+hbd_pkg::SYM_W-1:0] i_wr_data
);
    localparam int AW = $clog2(NODE_COUNT);
    localparam int DW = 2 * AW + hbd_pkg::SYM_W;

    logic [DW-1:0] r_mem [NODE_COUNT];
    logic [DW-1:0] r_q;
    logic [DW-1:0] r_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root <= '0;
        end else if (i_wr_en && i_wr_addr == '0) begin
            r_root <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data   = r_q;
    assign o_root_word = r_root;

endmodule
`default_nettype wire

@@ sv/hbd_walk.sv @@
// Tree walker: loads codes bit-serially and decodes data bytes bit-serially.
// Drives the node store ports and result events. Depends on hbd_pkg.
`default_nettype none
module hbd_walk #(
    parameter int NODE_COUNT   = hbd_pkg::NODE_COUNT_DEF,
    parameter int MAX_CODE_LEN = hbd_pkg::MAX_CODE_LEN_DEF
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_start,
    output logic                                         o_busy,
    input  wire logic                                    i_func,
    input  wire logic [7:0]                              i_symbol_in,
    input  wire logic [31:0]                             i_code_bits,
    input  wire logic [5:0]                              i_code_length,
    input  wire logic [7:0]                              i_data_byte,
    input  wire logic [3:0]                              i_valid_bits,
    input  wire logic [2*$clog2(NODE_COUNT)+hbd_pkg::SYM_W-1:0] i_rd_data,
    input  wire logic [2*$clog2(NODE_COUNT)+hbd_pkg::SYM_W-1:0] i_root_word,
    output logic                                         o_rd_en,
    output logic [$clog2(NODE_COUNT)-1:0]                o_rd_addr,
    output logic                                         o_wr_en,
    output logic [$clog2(NODE_COUNT)-1:0]                o_wr_addr,
    output logic [2*$clog2(NODE_COUNT)+hbd_pkg::SYM_W-1:0] o_wr_data,
    output hbd_pkg::t_res_ev                             o_ev
);
    localparam int AW  = $clog2(NODE_COUNT);
    localparam int UW  = $clog2(NODE_COUNT + 1);
    localparam int SW  = hbd_pkg::SYM_W;
    localparam int DW  = 2 * AW + SW;
    localparam int CW  = MAX_CODE_LEN;
    localparam int LW0 = $clog2(MAX_CODE_LEN + 1);
    localparam int LW  = (LW0 > 6) ? LW0 : 6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LSTEP,
        S_LWAIT,
        S_LFRESH,
        S_DSTEP,
        S_DWAIT,
        S_DONE
    } t_state;

    t_state                   r_state;
    logic                     r_func;
    logic [SW-1:0]            r_sym_in;
    logic [CW-1:0]            r_code;
    logic [7:0]               r_byte;
    logic [LW-1:0]            r_cnt;
    logic [hbd_pkg::POS_W-1:0] r_pos;
    logic [AW-1:0]            r_node;
    logic [DW-1:0]            r_word;
    logic                     r_at_root;
    logic [UW-1:0]            r_used;

    logic [DW-1:0]    cur_word;
    logic [AW-1:0]    cur_left;
    logic [AW-1:0]    cur_right;
    logic [AW-1:0]    child_l;
    logic [AW-1:0]    child_d;
    logic [AW-1:0]    fresh;
    logic             full;
    logic             rd_leaf;
    logic [DW-1:0]    upd_word;
    logic [LW-1:0]    len_in;
    logic [LW-1:0]    len_c;
    logic [CW+31:0]   code_ext;
    logic [CW+31:0]   code_shift;
    logic [3:0]       vb_c;

    assign cur_word  = r_at_root ? i_root_word : r_word;
    assign cur_left  = cur_word[DW-1 -: AW];
    assign cur_right = cur_word[AW+SW-1 -: AW];
    assign child_l   = r_code[CW-1] ? cur_right : cur_left;
    assign child_d   = r_byte[7] ? cur_right : cur_left;
    assign fresh     = r_used[AW-1:0];
    assign full      = (r_used == UW'(NODE_COUNT));
    assign rd_leaf   = (i_rd_data[DW-1 -: AW] == '0) && (i_rd_data[AW+SW-1 -: AW] == '0);
    assign upd_word  = r_code[CW-1] ? {cur_left, fresh, cur_word[SW-1:0]}
                                    : {fresh, cur_right, cur_word[SW-1:0]};

    // left-align the code so its first bit sits at the top of the shifter
    assign len_in     = LW'(i_code_length);
    assign len_c      = (len_in > LW'(CW)) ? LW'(CW) : len_in;
    assign code_ext   = (CW + 32)'(i_code_bits);
    assign code_shift = code_ext << (LW'(CW) - len_c);
    assign vb_c       = (i_valid_bits > 4'd8) ? 4'd8 : i_valid_bits;

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        o_rd_en   = 1'b0;
        o_rd_addr = child_l;
        o_wr_en   = 1'b0;
        o_wr_addr = r_node;
        o_wr_data = upd_word;
        o_ev      = '0;
        unique case (r_state)
            S_LSTEP: begin
                if (r_cnt == '0) begin
                    o_ev.push   = 1'b1;
                    o_ev.status = hbd_pkg::ST_LOADED;
                    o_wr_en     = (r_node != '0);
                    o_wr_data   = {cur_left, cur_right, r_sym_in};
                end else if (child_l != '0) begin
                    o_rd_en = 1'b1;
                end else if (full) begin
                    o_ev.push   = 1'b1;
                    o_ev.status = hbd_pkg::ST_FULL;
                end else begin
                    o_wr_en = 1'b1;
                end
            end
            S_LFRESH: begin
                o_wr_en   = 1'b1;
                o_wr_addr = fresh;
                o_wr_data = '0;
            end
            S_DSTEP: begin
                o_rd_addr = child_d;
                if (r_cnt != '0) begin
                    if (child_d == '0) begin
                        o_ev.push    = 1'b1;
                        o_ev.status  = hbd_pkg::ST_INVALID;
                        o_ev.bit_pos = r_pos;
                    end else begin
                        o_rd_en = 1'b1;
                    end
                end
            end
            S_DWAIT: begin
                if (rd_leaf) begin
                    o_ev.push    = 1'b1;
                    o_ev.status  = hbd_pkg::ST_SYMBOL;
                    o_ev.symbol  = i_rd_data[SW-1:0];
                    o_ev.bit_pos = r_pos;
                end
            end
            S_DONE: begin
                o_ev.flush = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_at_root <= 1'b1;
            r_used    <= UW'(1);
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_func   <= i_func;
                        r_sym_in <= i_symbol_in;
                        r_code   <= code_shift[CW-1:0];
                        r_byte   <= i_data_byte;
                        r_pos    <= '0;
                        if (i_func == hbd_pkg::FUNC_LOAD) begin
                            r_cnt     <= len_c;
                            r_node    <= '0;
                            r_at_root <= 1'b1;
                            r_state   <= S_LSTEP;
                        end else begin
                            r_cnt   <= LW'(vb_c);
                            r_state <= S_DSTEP;
                        end
                    end
                end
                S_LSTEP: begin
                    if (r_cnt == '0) begin
                        r_state <= S_DONE;
                    end else if (child_l != '0) begin
                        r_node  <= child_l;
                        r_code  <= r_code << 1;
                        r_cnt   <= r_cnt - LW'(1);
                        r_state <= S_LWAIT;
                    end else if (full) begin
                        r_state <= S_DONE;
                    end else begin
                        r_code  <= r_code << 1;
                        r_cnt   <= r_cnt - LW'(1);
                        r_state <= S_LFRESH;
                    end
                end
                S_LWAIT: begin
                    r_word    <= i_rd_data;
                    r_at_root <= 1'b0;
                    r_state   <= S_LSTEP;
                end
                S_LFRESH: begin
                    r_node    <= fresh;
                    r_word    <= '0;
                    r_at_root <= 1'b0;
                    r_used    <= r_used + UW'(1);
                    r_state   <= S_LSTEP;
                end
                S_DSTEP: begin
                    if (r_cnt == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_byte <= r_byte << 1;
                        r_cnt  <= r_cnt - LW'(1);
                        if (child_d == '0) begin
                            r_at_root <= 1'b1;
                            r_pos     <= r_pos + 3'd1;
                        end else begin
                            r_state <= S_DWAIT;
                        end
                    end
                end
                S_DWAIT: begin
                    if (rd_leaf) begin
                        r_at_root <= 1'b1;
                    end else begin
                        r_word    <= i_rd_data;
                        r_at_root <= 1'b0;
                    end
                    r_pos   <= r_pos + 3'd1;
                    r_state <= S_DSTEP;
                end
                S_DONE: begin
                    if (r_func == hbd_pkg::FUNC_LOAD) begin
                        r_at_root <= 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

@@ sv/hbd_result.sv @@
// Result stage: holds one result back so the last one of a transaction
// can be marked, then drives the one-cycle result strobe. Depends on hbd_pkg.
`default_nettype none
module hbd_result (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire hbd_pkg::t_res_ev              i_ev,
    output logic                               o_valid,
    output logic [hbd_pkg::SYM_W-1:0]          o_symbol,
    output logic [hbd_pkg::POS_W-1:0]          o_bit_position,
    output logic [1:0]                         o_status,
    output logic                               o_last
);
    logic                        r_pend_valid;
    logic [hbd_pkg::SYM_W-1:0]   r_pend_sym;
    logic [hbd_pkg::POS_W-1:0]   r_pend_pos;
    hbd_pkg::t_status            r_pend_st;
    logic                        r_valid;
    logic [hbd_pkg::SYM_W-1:0]   r_sym;
    logic [hbd_pkg::POS_W-1:0]   r_pos;
    hbd_pkg::t_status            r_st;
    logic                        r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_valid      <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (i_ev.push) begin
                if (r_pend_valid) begin
                    r_valid <= 1'b1;
                    r_sym   <= r_pend_sym;
                    r_pos   <= r_pend_pos;
                    r_st    <= r_pend_st;
                    r_last  <= 1'b0;
                end
                r_pend_valid <= 1'b1;
                r_pend_sym   <= i_ev.symbol;
                r_pend_pos   <= i_ev.bit_pos;
                r_pend_st    <= i_ev.status;
            end else if (i_ev.flush) begin
                if (r_pend_valid) begin
                    r_valid <= 1'b1;
                    r_sym   <= r_pend_sym;
                    r_pos   <= r_pend_pos;
                    r_st    <= r_pend_st;
                    r_last  <= 1'b1;
                end
                r_pend_valid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_valid;
    assign o_symbol       = r_sym;
    assign o_bit_position = r_pos;
    assign o_status       = r_st;
    assign o_last         = r_last;

endmodule
`default_nettype wire

@@ sv/huffman_tree_bit_decoder.sv @@
// Huffman decoder over a binary code tree, one code or data bit per step.
// Load: busy through a node read or a node allocation for each code bit, then the closing steps.
// Decode: a bit on a missing child needs no node-store read, any other bit one; then the closing steps.
// A result is held until the next one or the end of the transaction; the last one shows in
// the first idle cycle, whose edge can already accept the next transaction.
// Synchronous active-low reset empties the tree to the root and the walk; no result stall.
`default_nettype none
module huffman_tree_bit_decoder #(
    parameter int NODE_COUNT   = hbd_pkg::NODE_COUNT_DEF,
    parameter int MAX_CODE_LEN = hbd_pkg::MAX_CODE_LEN_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_func,
    input  wire logic [7:0]  i_symbol_in,
    input  wire logic [31:0] i_code_bits,
    input  wire logic [5:0]  i_code_length,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic [3:0]  i_valid_bits,
    output logic             o_valid,
    output logic [7:0]       o_symbol,
    output logic [2:0]       o_bit_position,
    output logic [1:0]       o_status,
    output logic             o_last
);
    localparam int AW = $clog2(NODE_COUNT);
    localparam int DW = 2 * AW + hbd_pkg::SYM_W;

    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [DW-1:0]    rd_data;
    logic [DW-1:0]    root_word;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [DW-1:0]    wr_data;
    hbd_pkg::t_res_ev ev;

    hbd_node_mem #(
        .NODE_COUNT (NODE_COUNT)
    ) u_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (rd_en),
        .i_rd_addr   (rd_addr),
        .o_rd_data   (rd_data),
        .o_root_word (root_word),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data)
    );

    hbd_walk #(
        .NODE_COUNT   (NODE_COUNT),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_walk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .o_busy        (busy),
        .i_func        (i_func),
        .i_symbol_in   (i_symbol_in),
        .i_code_bits   (i_code_bits),
        .i_code_length (i_code_length),
        .i_data_byte   (i_data_byte),
        .i_valid_bits  (i_valid_bits),
        .i_rd_data     (rd_data),
        .i_root_word   (root_word),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .o_ev          (ev)
    );

    hbd_result u_result (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ev           (ev),
        .o_valid        (o_valid),
        .o_symbol       (o_symbol),
        .o_bit_position (o_bit_position),
        .o_status       (o_status),
        .o_last         (o_last)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("transaction accepted but block not busy");

    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |=> !o_valid)
        else $error("result directly after last result of a transaction");

    a_load_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == hbd_pkg::ST_LOADED || o_status == hbd_pkg::ST_FULL)
        |-> o_last && o_bit_position == 3'd0 && o_symbol == 8'd0)
        else $error("load result malformed");

    a_invalid_sym: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == hbd_pkg::ST_INVALID |-> o_symbol == 8'd0)
        else $error("invalid-code result carries a symbol");

endmodule
`default_nettype wire
